/* design/text_console_cursor_writer_assert.svh */
// Assertion macros used by the console writer checker.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console writer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console writer check failed");

`endif

/* design/tccw_pkg.sv */
// Shared types, command and character codes, and defaults for the console writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;

   localparam int DEF_SCREEN_COLS = 80;
   localparam int DEF_SCREEN_ROWS = 25;
   localparam int DEF_TAB_STEP    = 4;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ATTR_W-1:0] attr_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam cmd_type CMD_PUT      = 3'd0;
   localparam cmd_type CMD_PUT_ATTR = 3'd1;
   localparam cmd_type CMD_SET_ATTR = 3'd2;
   localparam cmd_type CMD_CLEAR    = 3'd3;
   localparam cmd_type CMD_MOVE     = 3'd4;

   localparam char_type CH_NUL = 8'd0;
   localparam char_type CH_BS  = 8'd8;
   localparam char_type CH_TAB = 8'd9;
   localparam char_type CH_LF  = 8'd10;
   localparam char_type CH_CR  = 8'd13;

   localparam attr_type ATTR_RESET   = 8'h0E;
   localparam attr_type ATTR_DEFAULT = 8'h0A;

   // Flags produced by one character step.
   typedef struct packed {
      logic write_en;
      logic screen_clr;
   } step_flags_type;

endpackage

`default_nettype wire

/* design/tccw_if.sv */
// Request and response channel interfaces of the console writer.
`timescale 1ns / 1ps
`default_nettype none

interface tccw_req_if;
   import tccw_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  cmd;
   char_type ch;
   attr_type attr;
   row_type  row;
   col_type  col;

   modport source (output valid, cmd, ch, attr, row, col, input ready);
   modport sink (input valid, cmd, ch, attr, row, col, output ready);
endinterface

interface tccw_rsp_if;
   import tccw_pkg::*;

   logic     valid;
   logic     ready;
   logic     write_en;
   addr_type cell_addr;
   char_type cell_char;
   attr_type cell_attr;
   logic     screen_clr;
   row_type  cursor_row;
   col_type  cursor_col;
   addr_type cursor_loc;

   modport source (output valid, write_en, cell_addr, cell_char, cell_attr, screen_clr,
                   cursor_row, cursor_col, cursor_loc, input ready);
   modport sink (input valid, write_en, cell_addr, cell_char, cell_attr, screen_clr,
                 cursor_row, cursor_col, cursor_loc, output ready);
endinterface

`default_nettype wire

/* design/text_console_cursor_writer.sv */
// Text console cursor writer: top level with cursor state and the response register.
//
// One command beat is taken every clock cycle while responses drain; its response
// beat appears in the cycle after acceptance, held until taken. The cursor row,
// column and attribute update in the same cycle that a beat is accepted, so the next
// beat may follow immediately; the response register lets a new beat enter in the
// cycle the previous response is taken, and the request side stalls only when that
// register is full and not being drained. The sustained rate of one beat per cycle
// while responses drain is set by the cursor update loop. Each response carries the
// optional cell write, the optional screen clear and the new cursor location.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_writer #(
   parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_STEP    = tccw_pkg::DEF_TAB_STEP
) (
   input wire logic  clock,
   input wire logic  reset,
   tccw_req_if.sink   req_chan,
   tccw_rsp_if.source rsp_chan
);
   import tccw_pkg::*;

   localparam int ROW_IW = ($clog2(SCREEN_ROWS) > ROW_W) ? $clog2(SCREEN_ROWS) : ROW_W;
   localparam int COL_IW = ($clog2(SCREEN_COLS) > COL_W) ? $clog2(SCREEN_COLS) : COL_W;

   logic [ROW_IW-1:0] cur_row_ff, cur_row_in;
   logic [COL_IW-1:0] cur_col_ff, cur_col_in;
   attr_type          cur_attr_ff, cur_attr_in;

   step_flags_type    flags;
   logic [ROW_IW-1:0] wr_row;
   logic [COL_IW-1:0] wr_col;
   addr_type          wr_loc;
   addr_type          cur_loc;

   logic     out_valid_ff;
   logic     write_en_ff;
   addr_type cell_addr_ff;
   char_type cell_char_ff;
   attr_type cell_attr_ff;
   logic     screen_clr_ff;
   row_type  cursor_row_ff;
   col_type  cursor_col_ff;
   addr_type cursor_loc_ff;

   logic accept;

   tccw_step #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .TAB_STEP   (TAB_STEP),
      .ROW_IW     (ROW_IW),
      .COL_IW     (COL_IW)
   ) u_step (
      .cmd     (req_chan.cmd),
      .ch      (req_chan.ch),
      .attr    (req_chan.attr),
      .row     (req_chan.row),
      .col     (req_chan.col),
      .cur_row (cur_row_ff),
      .cur_col (cur_col_ff),
      .cur_attr(cur_attr_ff),
      .nxt_row (cur_row_in),
      .nxt_col (cur_col_in),
      .nxt_attr(cur_attr_in),
      .flags   (flags),
      .wr_row  (wr_row),
      .wr_col  (wr_col)
   );

   tccw_loc #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .ROW_IW     (ROW_IW),
      .COL_IW     (COL_IW)
   ) u_wr_loc (
      .row(wr_row),
      .col(wr_col),
      .loc(wr_loc)
   );

   tccw_loc #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .ROW_IW     (ROW_IW),
      .COL_IW     (COL_IW)
   ) u_cur_loc (
      .row(cur_row_in),
      .col(cur_col_in),
      .loc(cur_loc)
   );

   assign req_chan.ready = (!out_valid_ff || rsp_chan.ready) && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_attr_ff  <= ATTR_RESET;
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_attr_ff  <= cur_attr_in;
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Response payload; write fields read as zero when no cell is written.
   always_ff @(posedge clock) begin
      if (accept) begin
         write_en_ff   <= flags.write_en;
         screen_clr_ff <= flags.screen_clr;
         cell_addr_ff  <= flags.write_en ? wr_loc : '0;
         cell_char_ff  <= flags.write_en ? req_chan.ch : '0;
         cell_attr_ff  <= flags.write_en ? cur_attr_in : '0;
         cursor_row_ff <= ROW_W'(cur_row_in);
         cursor_col_ff <= COL_W'(cur_col_in);
         cursor_loc_ff <= cur_loc;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.write_en   = write_en_ff;
   assign rsp_chan.cell_addr  = cell_addr_ff;
   assign rsp_chan.cell_char  = cell_char_ff;
   assign rsp_chan.cell_attr  = cell_attr_ff;
   assign rsp_chan.screen_clr = screen_clr_ff;
   assign rsp_chan.cursor_row = cursor_row_ff;
   assign rsp_chan.cursor_col = cursor_col_ff;
   assign rsp_chan.cursor_loc = cursor_loc_ff;

endmodule

`default_nettype wire

/* design/tccw_loc.sv */
// Linear cell index row*SCREEN_COLS+col, truncated to the address field.
`timescale 1ns / 1ps
`default_nettype none

module tccw_loc #(
   parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int ROW_IW = ($clog2(SCREEN_ROWS) > tccw_pkg::ROW_W) ?
                          $clog2(SCREEN_ROWS) : tccw_pkg::ROW_W,
   parameter int COL_IW = ($clog2(SCREEN_COLS) > tccw_pkg::COL_W) ?
                          $clog2(SCREEN_COLS) : tccw_pkg::COL_W
) (
   input  wire logic [ROW_IW-1:0] row,
   input  wire logic [COL_IW-1:0] col,
   output tccw_pkg::addr_type     loc
);
   import tccw_pkg::*;

   localparam int LOC_IW = ROW_IW + COL_IW + 1;

   logic [LOC_IW-1:0] prod;

   // Constant multiply; synthesis reduces it to a few shifted adds.
   assign prod = LOC_IW'(row) * LOC_IW'(SCREEN_COLS) + LOC_IW'(col);
   assign loc  = ADDR_W'(prod);

endmodule

`default_nettype wire

/* design/tccw_step.sv */
// Next cursor and attribute state, the cell write and the screen clear for one command.
`timescale 1ns / 1ps
`default_nettype none

module tccw_step #(
   parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_STEP    = tccw_pkg::DEF_TAB_STEP,
   parameter int ROW_IW = ($clog2(SCREEN_ROWS) > tccw_pkg::ROW_W) ?
                          $clog2(SCREEN_ROWS) : tccw_pkg::ROW_W,
   parameter int COL_IW = ($clog2(SCREEN_COLS) > tccw_pkg::COL_W) ?
                          $clog2(SCREEN_COLS) : tccw_pkg::COL_W
) (
   input  wire tccw_pkg::cmd_type    cmd,
   input  wire tccw_pkg::char_type   ch,
   input  wire tccw_pkg::attr_type   attr,
   input  wire tccw_pkg::row_type    row,
   input  wire tccw_pkg::col_type    col,
   input  wire logic [ROW_IW-1:0]    cur_row,
   input  wire logic [COL_IW-1:0]    cur_col,
   input  wire tccw_pkg::attr_type   cur_attr,
   output logic [ROW_IW-1:0]         nxt_row,
   output logic [COL_IW-1:0]         nxt_col,
   output tccw_pkg::attr_type        nxt_attr,
   output tccw_pkg::step_flags_type  flags,
   output logic [ROW_IW-1:0]         wr_row,
   output logic [COL_IW-1:0]         wr_col
);
   import tccw_pkg::*;

   localparam logic [ROW_IW-1:0] LastRow = ROW_IW'(SCREEN_ROWS - 1);
   localparam logic [COL_IW-1:0] LastCol = COL_IW'(SCREEN_COLS - 1);
   localparam logic [COL_IW:0]   TabLim  = (COL_IW + 1)'(SCREEN_COLS - 2);
   localparam logic [COL_IW:0]   TabInc  = (COL_IW + 1)'(TAB_STEP);
   localparam logic [ROW_IW:0]   RowsExt = (ROW_IW + 1)'(SCREEN_ROWS);
   localparam logic [COL_IW:0]   ColsExt = (COL_IW + 1)'(SCREEN_COLS);

   logic [ROW_IW:0]   row_inc;
   logic              at_bottom;
   logic [COL_IW:0]   tab_sum;
   attr_type          attr_sel;
   attr_type          attr_put;
   logic [ROW_IW-1:0] row_req;
   logic [COL_IW-1:0] col_req;

   assign row_inc   = {1'b0, cur_row} + (ROW_IW + 1)'(1);
   assign at_bottom = (row_inc >= RowsExt);
   assign tab_sum   = {1'b0, cur_col} + TabInc;
   assign attr_sel  = (cmd == CMD_PUT_ATTR) ? attr : cur_attr;
   assign attr_put  = (attr_sel == '0) ? ATTR_DEFAULT : attr_sel;
   assign row_req   = ROW_IW'(row);
   assign col_req   = COL_IW'(col);

   always_comb begin
      nxt_row  = cur_row;
      nxt_col  = cur_col;
      nxt_attr = cur_attr;
      flags    = '0;
      wr_row   = '0;
      wr_col   = '0;
      unique case (cmd)
         CMD_PUT, CMD_PUT_ATTR: begin
            nxt_attr = attr_put;
            case (ch) inside
               CH_NUL: begin
               end
               CH_LF, CH_CR: begin
                  // Leaving the last row clears and replays the newline from home.
                  if (at_bottom) begin
                     flags.screen_clr = 1'b1;
                     nxt_row = ROW_IW'(1);
                  end else begin
                     nxt_row = ROW_IW'(row_inc);
                  end
                  nxt_col = '0;
               end
               CH_TAB: begin
                  if (tab_sum >= TabLim) begin
                     nxt_col = COL_IW'(TabLim);
                  end else begin
                     nxt_col = COL_IW'(tab_sum);
                  end
               end
               CH_BS: begin
                  if (cur_col == '0) begin
                     if (cur_row == '0) begin
                        flags.screen_clr = 1'b1;
                     end else begin
                        nxt_row = cur_row - ROW_IW'(1);
                        nxt_col = LastCol;
                     end
                  end else begin
                     nxt_col = cur_col - COL_IW'(1);
                  end
               end
               default: begin
                  flags.write_en = 1'b1;
                  if (cur_col >= LastCol) begin
                     // Wrap to the next row; past the bottom the screen clears and
                     // the character lands at home.
                     if (at_bottom) begin
                        flags.screen_clr = 1'b1;
                        wr_row = '0;
                     end else begin
                        wr_row = ROW_IW'(row_inc);
                     end
                     wr_col = '0;
                  end else begin
                     wr_row = cur_row;
                     wr_col = cur_col;
                  end
                  nxt_row = wr_row;
                  nxt_col = wr_col + COL_IW'(1);
               end
            endcase
         end
         CMD_SET_ATTR: begin
            nxt_attr = attr;
         end
         CMD_CLEAR: begin
            flags.screen_clr = 1'b1;
            nxt_row = '0;
            nxt_col = '0;
         end
         CMD_MOVE: begin
            // Compare one bit wider so a screen size that fills the field still fits.
            nxt_row = ({1'b0, row_req} < RowsExt) ? row_req : LastRow;
            nxt_col = ({1'b0, col_req} < ColsExt) ? col_req : LastCol;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/tccw_checker.sv */
// Port-level checks for the console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_cursor_writer_assert.svh"

module tccw_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               write_en,
   input wire tccw_pkg::addr_type cell_addr,
   input wire tccw_pkg::char_type cell_char,
   input wire tccw_pkg::attr_type cell_attr,
   input wire tccw_pkg::addr_type cursor_loc
);
   import tccw_pkg::*;

   // No response beat may be pending right after reset.
   `TCCW_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Every accepted command beat shows up as a response in the next cycle.
   `TCCW_ASSERT_NEXT(a_accept_resp, clock, reset, req_valid && req_ready, rsp_valid)

   // A stalled response stays put.
   `TCCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(cell_addr) && $stable(cursor_loc))

   // Without a cell write the write fields are all zero.
   `TCCW_ASSERT_SAME(a_idle_write, clock, reset, rsp_valid && !write_en,
                     cell_addr == '0 && cell_char == '0 && cell_attr == '0)

   // A written cell never carries a null character or a zero attribute.
   `TCCW_ASSERT_SAME(a_write_nonzero, clock, reset, rsp_valid && write_en,
                     cell_char != '0 && cell_attr != '0)

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .write_en  (rsp_chan.write_en),
   .cell_addr (rsp_chan.cell_addr),
   .cell_char (rsp_chan.cell_char),
   .cell_attr (rsp_chan.cell_attr),
   .cursor_loc(rsp_chan.cursor_loc)
);

`default_nettype wire
